// ----- hw/rtl/assert_macros.svh -----
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_HOLDS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
	else $error("assertion failed: lbl");
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed: lbl");
`else
`define AST_HOLDS(lbl, clk, rst_n, expr)
`define AST_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/bda_pkg.sv -----
`default_nettype none
package bda_pkg;

	localparam int SCALE      = 4;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int CFG_W  = 11;
	localparam int PIX_W  = 8;
	localparam int RS_W   = 10;
	localparam int ACC_W  = 11;
	localparam int SUB_W  = 3;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);

	localparam logic CFG_OUT_WIDTH  = 1'b0;
	localparam logic CFG_OUT_HEIGHT = 1'b1;

	// Division by SCALE as a multiply by a rounded-up reciprocal; exact for
	// every value below two to the ACC_W.
	localparam int DIV_K  = 14;
	localparam int DIV_M  = ((1 << DIV_K) + SCALE - 1) / SCALE;
	localparam int PROD_W = ACC_W + DIV_K;

	function automatic logic [PIX_W-1:0] div_scale(input logic [ACC_W-1:0] v);
		logic [PROD_W-1:0] p;
		p = PROD_W'(v) * PROD_W'(DIV_M);
		return p[DIV_K+PIX_W-1:DIV_K];
	endfunction

	function automatic logic [COL_W:0] clamp_width(input logic [CFG_W-1:0] v);
		logic [COL_W:0] r;
		if (v == '0) begin
			r = (COL_W+1)'(1);
		end else if (int'(v) > MAX_WIDTH) begin
			r = (COL_W+1)'(MAX_WIDTH);
		end else begin
			r = (COL_W+1)'(v);
		end
		return r;
	endfunction

	function automatic logic [ROW_W:0] clamp_height(input logic [CFG_W-1:0] v);
		logic [ROW_W:0] r;
		if (v == '0) begin
			r = (ROW_W+1)'(1);
		end else if (int'(v) > MAX_HEIGHT) begin
			r = (ROW_W+1)'(MAX_HEIGHT);
		end else begin
			r = (ROW_W+1)'(v);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/box_downsample_to_alpha.sv -----
// Pipeline: the beat that carries the last pixel of its block goes through the
// line buffer read, then the update and output queue write, before its result is offered.
// Throughput: one pixel per cycle while pix_stall is low; the single column buffer is read once and
// written once per SCALE pixels, and a two-entry output queue absorbs stalls.
// Reset: counters clear, sizes return to 1; the column buffer is not cleared,
// as the first row of every block row overwrites it.
`default_nettype none
`include "assert_macros.svh"
module box_downsample_to_alpha (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          cfg_index,
	input  wire logic [bda_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          pix_valid,
	output logic                               pix_stall,
	input  wire logic [bda_pkg::PIX_W-1:0]     red_value,
	output logic                               alpha_valid,
	input  wire logic                          alpha_stall,
	output logic [bda_pkg::PIX_W-1:0]          alpha_value,
	output logic                               frame_last
);

	logic [bda_pkg::CFG_W-1:0] width_q;
	logic [bda_pkg::CFG_W-1:0] height_q;
	logic [bda_pkg::COL_W:0]   w_eff;
	logic [bda_pkg::ROW_W:0]   h_eff;

	logic [bda_pkg::RS_W-1:0]  row_sum_q;
	logic [bda_pkg::SUB_W-1:0] sub_column_q;
	logic [bda_pkg::SUB_W-1:0] sub_row_q;
	logic [bda_pkg::COL_W-1:0] column_index_q;
	logic [bda_pkg::ROW_W-1:0] row_index_q;

	logic                      accept;
	logic [bda_pkg::RS_W-1:0]  sum;
	logic                      grp_done;
	logic                      last_col;
	logic                      last_row;
	logic                      emit;
	logic [bda_pkg::PIX_W-1:0] havg;

	logic                      valid_s1;
	logic [bda_pkg::PIX_W-1:0] havg_s1;
	logic [bda_pkg::COL_W-1:0] col_s1;
	logic                      first_s1;
	logic                      emit_s1;
	logic                      last_s1;

	logic [bda_pkg::RS_W-1:0]  col_mem [bda_pkg::MAX_WIDTH];
	logic [bda_pkg::RS_W-1:0]  rd_q;
	logic [bda_pkg::ACC_W-1:0] acc;

	logic [bda_pkg::PIX_W-1:0] alpha_fifo [2];
	logic                      last_fifo [2];
	logic                      wr_ptr_q;
	logic                      rd_ptr_q;
	logic [1:0]                occ_q;
	logic                      push;
	logic                      pop;
	logic [2:0]                demand;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bda_pkg::CFG_W'(1);
			height_q <= bda_pkg::CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bda_pkg::CFG_OUT_WIDTH:  width_q  <= cfg_data;
				bda_pkg::CFG_OUT_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_eff = bda_pkg::clamp_width(width_q);
	assign h_eff = bda_pkg::clamp_height(height_q);

	assign accept   = pix_valid && !pix_stall;
	assign sum      = row_sum_q + bda_pkg::RS_W'(red_value);
	assign grp_done = accept && (sub_column_q == bda_pkg::SUB_W'(bda_pkg::SCALE - 1));
	assign havg     = bda_pkg::div_scale(bda_pkg::ACC_W'(sum));
	assign last_col = ((bda_pkg::COL_W+1)'(column_index_q) + (bda_pkg::COL_W+1)'(1)) >= w_eff;
	assign last_row = ((bda_pkg::ROW_W+1)'(row_index_q) + (bda_pkg::ROW_W+1)'(1)) >= h_eff;
	assign emit     = (sub_row_q == bda_pkg::SUB_W'(bda_pkg::SCALE - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_sum_q      <= '0;
			sub_column_q   <= '0;
			sub_row_q      <= '0;
			column_index_q <= '0;
			row_index_q    <= '0;
		end else if (grp_done) begin
			row_sum_q    <= '0;
			sub_column_q <= '0;
			if (last_col) begin
				column_index_q <= '0;
				if (emit) begin
					sub_row_q <= '0;
					if (last_row) begin
						row_index_q <= '0;
					end else begin
						row_index_q <= row_index_q + bda_pkg::ROW_W'(1);
					end
				end else begin
					sub_row_q <= sub_row_q + bda_pkg::SUB_W'(1);
				end
			end else begin
				column_index_q <= column_index_q + bda_pkg::COL_W'(1);
			end
		end else if (accept) begin
			row_sum_q    <= sum;
			sub_column_q <= sub_column_q + bda_pkg::SUB_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= grp_done;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_done) begin
			havg_s1  <= havg;
			col_s1   <= column_index_q;
			first_s1 <= (sub_row_q == '0);
			emit_s1  <= emit;
			last_s1  <= last_col && last_row;
		end
	end

	// A group needs SCALE accepted pixels, so a read never meets the
	// pending write of the same column.
	always_ff @(posedge clk) begin
		if (grp_done) begin
			rd_q <= col_mem[column_index_q];
		end
		if (valid_s1) begin
			col_mem[col_s1] <= acc[bda_pkg::RS_W-1:0];
		end
	end

	assign acc = first_s1 ? bda_pkg::ACC_W'(havg_s1)
	                      : bda_pkg::ACC_W'(rd_q) + bda_pkg::ACC_W'(havg_s1);

	assign push        = valid_s1 && emit_s1;
	assign alpha_valid = (occ_q != 2'd0);
	assign pop         = alpha_valid && !alpha_stall;
	assign demand      = 3'(occ_q) + 3'(push);
	assign pix_stall   = (demand >= 3'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			occ_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			occ_q <= occ_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			alpha_fifo[wr_ptr_q] <= bda_pkg::div_scale(acc);
			last_fifo[wr_ptr_q]  <= last_s1;
		end
	end

	assign alpha_value = alpha_fifo[rd_ptr_q];
	assign frame_last  = last_fifo[rd_ptr_q];

	`AST_HOLDS(a_no_overlap, clk, arst_n, !(valid_s1 && grp_done))
	`AST_HOLDS(a_occ_bound, clk, arst_n, occ_q <= 2'd2)
	`AST_HOLDS(a_no_overflow, clk, arst_n, !(push && occ_q == 2'd2))
	`AST_NEXT(a_frame_wrap, clk, arst_n, grp_done && emit && last_col && last_row, column_index_q == '0 && row_index_q == '0 && sub_row_q == '0)

endmodule
`default_nettype wire

// ----- tb/box_downsample_to_alpha_test.sv -----
module box_downsample_to_alpha_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [bda_pkg::PIX_W-1:0] alpha;
		logic                      last;
	} alpha_beat_t;

	// Tracks the downsampler state and queues the alpha beats it should emit.
	class box_average_predictor;
		logic [bda_pkg::CFG_W-1:0] width_reg;
		logic [bda_pkg::CFG_W-1:0] height_reg;
		logic [bda_pkg::RS_W-1:0]  row_sum;
		logic [bda_pkg::SUB_W-1:0] sub_column;
		logic [bda_pkg::SUB_W-1:0] sub_row;
		logic [bda_pkg::COL_W-1:0] column_index;
		logic [bda_pkg::ROW_W-1:0] row_index;
		logic [bda_pkg::RS_W-1:0]  column_sums [bda_pkg::MAX_WIDTH];
		alpha_beat_t               alpha_expected [$];
		int                        errors;

		function new();
			width_reg = bda_pkg::CFG_W'(1);
			height_reg = bda_pkg::CFG_W'(1);
			row_sum = '0;
			sub_column = '0;
			sub_row = '0;
			column_index = '0;
			row_index = '0;
			foreach (column_sums[i]) column_sums[i] = '0;
			errors = 0;
		endfunction

		task report_mismatch(input string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function void set_size(input logic idx, input logic [bda_pkg::CFG_W-1:0] v);
			if (idx == bda_pkg::CFG_OUT_WIDTH) begin
				width_reg = v;
			end else begin
				height_reg = v;
			end
		endfunction

		function int clamp_size(input logic [bda_pkg::CFG_W-1:0] v, input int limit);
			if (v == '0) return 1;
			if (int'(v) > limit) return limit;
			return int'(v);
		endfunction

		function bit at_block_row_start();
			return sub_column == '0 && sub_row == '0 && column_index == '0;
		endfunction

		function bit at_frame_start();
			return at_block_row_start() && row_index == '0;
		endfunction

		function int pending();
			return alpha_expected.size();
		endfunction

		function void take_pixel(input logic [bda_pkg::PIX_W-1:0] red);
			int w;
			int h;
			int col;
			int havg;
			int acc;
			alpha_beat_t beat;
			w = clamp_size(width_reg, bda_pkg::MAX_WIDTH);
			h = clamp_size(height_reg, bda_pkg::MAX_HEIGHT);
			row_sum = row_sum + red;
			sub_column = sub_column + 1'b1;
			if (int'(sub_column) < bda_pkg::SCALE) return;
			havg = int'(row_sum) / bda_pkg::SCALE;
			row_sum = '0;
			sub_column = '0;
			col = (int'(column_index) >= bda_pkg::MAX_WIDTH) ? bda_pkg::MAX_WIDTH - 1
				: int'(column_index);
			if (sub_row == '0) begin
				acc = havg;
			end else begin
				acc = int'(column_sums[col]) + havg;
			end
			column_sums[col] = bda_pkg::RS_W'(acc);
			if (int'(sub_row) + 1 >= bda_pkg::SCALE) begin
				beat.alpha = bda_pkg::PIX_W'(acc / bda_pkg::SCALE);
				beat.last = (int'(column_index) + 1 >= w) && (int'(row_index) + 1 >= h);
				alpha_expected.push_back(beat);
			end
			if (int'(column_index) + 1 >= w) begin
				column_index = '0;
				if (int'(sub_row) + 1 >= bda_pkg::SCALE) begin
					sub_row = '0;
					if (int'(row_index) + 1 >= h) begin
						row_index = '0;
					end else begin
						row_index = row_index + 1'b1;
					end
				end else begin
					sub_row = sub_row + 1'b1;
				end
			end else begin
				column_index = column_index + 1'b1;
			end
		endfunction

		task check_alpha(input logic [bda_pkg::PIX_W-1:0] alpha, input logic last);
			alpha_beat_t want;
			if (alpha_expected.size() == 0) begin
				report_mismatch($sformatf("unexpected alpha beat %0d last %0b", alpha, last));
			end else begin
				want = alpha_expected.pop_front();
				if (alpha !== want.alpha) begin
					report_mismatch($sformatf("alpha_value got %0d expected %0d",
						alpha, want.alpha));
				end
				if (last !== want.last) begin
					report_mismatch($sformatf("frame_last got %b expected %b",
						last, want.last));
				end
			end
		endtask
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic                       cfg_index = 1'b0;
	logic [bda_pkg::CFG_W-1:0]  cfg_data = '0;
	logic                       pix_valid = 1'b0;
	logic                       pix_stall;
	logic [bda_pkg::PIX_W-1:0]  red_value = '0;
	logic                       alpha_valid;
	logic                       alpha_stall = 1'b0;
	logic [bda_pkg::PIX_W-1:0]  alpha_value;
	logic                       frame_last;

	box_average_predictor predictor;
	int                   cycle_count = 0;
	int                   pixels_sent = 0;

	box_downsample_to_alpha dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.red_value   (red_value),
		.alpha_valid (alpha_valid),
		.alpha_stall (alpha_stall),
		.alpha_value (alpha_value),
		.frame_last  (frame_last)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Both sides run without gaps in the last quarter of every steady_stretch window.
	function automatic bit steady_stretch();
		return (cycle_count % 2000) >= 1500;
	endfunction

	always @(posedge clk) begin
		alpha_stall <= !steady_stretch() && ($urandom_range(99) < 35);
	end

	always @(posedge clk) begin
		if (arst_n && alpha_valid && !alpha_stall) begin
			predictor.check_alpha(alpha_value, frame_last);
		end
	end

	function automatic logic [bda_pkg::PIX_W-1:0] random_red();
		if ($urandom_range(3) == 0) return 8'hFF;
		return bda_pkg::PIX_W'($urandom_range(255));
	endfunction

	task send_pixel(input logic [bda_pkg::PIX_W-1:0] red);
		while (!steady_stretch() && $urandom_range(99) < 35) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		red_value <= red;
		do @(posedge clk); while (pix_stall);
		predictor.take_pixel(red);
		pixels_sent++;
	endtask

	task go_idle();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (predictor.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_size(input logic idx, input logic [bda_pkg::CFG_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		predictor.set_size(idx, v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Sizes may also change at the start of a block row, where the line buffer
	// is about to be rewritten, so no unwritten column is ever read.
	task run_frames(input logic [bda_pkg::CFG_W-1:0] w, input logic [bda_pkg::CFG_W-1:0] h,
			input int frames, input bit resize);
		int done;
		go_idle();
		write_size(bda_pkg::CFG_OUT_WIDTH, w);
		write_size(bda_pkg::CFG_OUT_HEIGHT, h);
		done = 0;
		while (done < frames) begin
			send_pixel(random_red());
			if (predictor.at_frame_start()) begin
				done++;
			end else if (resize && predictor.at_block_row_start() &&
					$urandom_range(7) == 0) begin
				go_idle();
				write_size(bda_pkg::CFG_OUT_HEIGHT, bda_pkg::CFG_W'($urandom_range(0, 8)));
				if ($urandom_range(1) == 1) begin
					write_size(bda_pkg::CFG_OUT_WIDTH, bda_pkg::CFG_W'($urandom_range(0, 12)));
				end
			end
		end
	endtask

	initial begin
		predictor = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		repeat (16) send_pixel(8'hFF);
		for (int i = 0; i < 16; i++) begin
			send_pixel(i[0] ? 8'hFF : 8'h00);
		end

		run_frames('0, '0, 1, 1'b0);
		run_frames(bda_pkg::CFG_W'(3), bda_pkg::CFG_W'(2), 2, 1'b1);

		while (pixels_sent < 1600) begin
			if ($urandom_range(7) == 0) begin
				run_frames(bda_pkg::CFG_W'($urandom_range(16, 32)), bda_pkg::CFG_W'(1),
					1, 1'b0);
			end else begin
				run_frames(bda_pkg::CFG_W'($urandom_range(1, 8)),
					bda_pkg::CFG_W'($urandom_range(1, 4)), $urandom_range(1, 2), 1'b1);
			end
		end

		go_idle();
		repeat (8) @(posedge clk);
		if (predictor.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
